@@ design/atpg_pkg.sv @@
// Shared types, constants and the quarter-wave sine ROM of the test pattern generator.
// No dependencies; used by alpha_test_pattern_pixel_generator_unit and its testbench.
package atpg_pkg;

   localparam int DIM_W   = 13;
   localparam int COORD_W = 12;
   localparam int PHASE_W = 7;
   localparam int GAIN_W  = 11;
   localparam int QUO_W   = 13;

   localparam int PHASE_COUNT = 120;
   localparam int QUARTER     = PHASE_COUNT / 4;

   localparam logic [DIM_W-1:0]  MIN_DIM       = 13'd64;
   localparam logic [DIM_W-1:0]  WIDTH_RESET   = 13'd1920;
   localparam logic [DIM_W-1:0]  HEIGHT_RESET  = 13'd1080;
   localparam logic [GAIN_W-1:0] GAIN_RESET    = 11'd1024;
   localparam logic [GAIN_W-1:0] NO_SCALE_GAIN = 11'd1023;

   localparam logic [1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_FRAME_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_ALPHA_GAIN   = 2'd2;

   typedef struct packed {
      logic [COORD_W-1:0] pixel_x;
      logic [COORD_W-1:0] pixel_y;
      logic [PHASE_W-1:0] frame_phase;
   } req_type;

   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
      logic [7:0] alpha;
   } rsp_type;

   typedef struct packed {
      logic        neg;
      logic [15:0] mag;
   } trig_type;

   // Q1.15 sine over one quarter wave, 3 degrees a step
   function automatic logic [15:0] quarter_sine(input logic [4:0] idx);
      logic [15:0] v;
      unique case (idx)
         5'd0:  v = 16'd0;
         5'd1:  v = 16'd1715;
         5'd2:  v = 16'd3425;
         5'd3:  v = 16'd5126;
         5'd4:  v = 16'd6813;
         5'd5:  v = 16'd8481;
         5'd6:  v = 16'd10126;
         5'd7:  v = 16'd11743;
         5'd8:  v = 16'd13328;
         5'd9:  v = 16'd14876;
         5'd10: v = 16'd16384;
         5'd11: v = 16'd17847;
         5'd12: v = 16'd19261;
         5'd13: v = 16'd20622;
         5'd14: v = 16'd21926;
         5'd15: v = 16'd23170;
         5'd16: v = 16'd24351;
         5'd17: v = 16'd25466;
         5'd18: v = 16'd26510;
         5'd19: v = 16'd27482;
         5'd20: v = 16'd28378;
         5'd21: v = 16'd29197;
         5'd22: v = 16'd29935;
         5'd23: v = 16'd30592;
         5'd24: v = 16'd31164;
         5'd25: v = 16'd31651;
         5'd26: v = 16'd32052;
         5'd27: v = 16'd32365;
         5'd28: v = 16'd32588;
         5'd29: v = 16'd32723;
         5'd30: v = 16'd32768;
         default: v = 16'd0;
      endcase
      return v;
   endfunction

   // full-wave sine for a phase already below PHASE_COUNT
   function automatic trig_type rom_sine(input logic [PHASE_W-1:0] p);
      logic [1:0]         q;
      logic [PHASE_W-1:0] r;
      logic [4:0]         idx;
      trig_type           t;
      priority if (p < PHASE_W'(QUARTER)) begin
         q = 2'd0;
         r = p;
      end else if (p < PHASE_W'(2 * QUARTER)) begin
         q = 2'd1;
         r = p - PHASE_W'(QUARTER);
      end else if (p < PHASE_W'(3 * QUARTER)) begin
         q = 2'd2;
         r = p - PHASE_W'(2 * QUARTER);
      end else begin
         q = 2'd3;
         r = p - PHASE_W'(3 * QUARTER);
      end
      idx   = q[0] ? 5'(PHASE_W'(QUARTER) - r) : r[4:0];
      t.mag = quarter_sine(idx);
      t.neg = q[1];
      return t;
   endfunction

endpackage

@@ design/alpha_test_pattern_pixel_generator_unit.sv @@
// Alpha test pattern generator top: register file, geometry setup and pixel pipeline.
// Depends on atpg_pkg and atpg_div.
// A taken start beat runs down the valid shift register, then rsp_valid is registered.
// Throughput: one pixel per clock while busy is low; depth is set by the 13-stage quotient pipelines.
// After reset and after every register write, busy is high while the
// frame geometry registers settle. The result side cannot stall.
module alpha_test_pattern_pixel_generator_unit #(
   parameter int MAX_DIM = 4096
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  atpg_pkg::req_type   req_data,
   output logic                rsp_valid,
   output atpg_pkg::rsp_type   rsp_data,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [3:0]          paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready
);

   localparam int DIM_W    = atpg_pkg::DIM_W;
   localparam int COORD_W  = atpg_pkg::COORD_W;
   localparam int PHASE_W  = atpg_pkg::PHASE_W;
   localparam int GAIN_W   = atpg_pkg::GAIN_W;
   localparam int QUO_W    = atpg_pkg::QUO_W;
   localparam int DIV_DONE = 1 + QUO_W;
   localparam int REG_DLY  = DIV_DONE - 4;
   localparam logic [1:0] SETTLE_CYCLES = 2'd3;

   typedef struct packed {
      logic border;
      logic circle;
      logic rect;
      logic moving;
   } region_type;

   // register file
   logic [DIM_W-1:0]  frame_width_ff, frame_height_ff;
   logic [GAIN_W-1:0] alpha_gain_ff;
   logic [1:0]        settle_ff;
   logic              csr_write;
   logic              accept;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign busy      = (settle_ff != 2'd0);
   assign accept    = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= atpg_pkg::WIDTH_RESET;
         frame_height_ff <= atpg_pkg::HEIGHT_RESET;
         alpha_gain_ff   <= atpg_pkg::GAIN_RESET;
         settle_ff       <= SETTLE_CYCLES;
      end else begin
         if (csr_write) begin
            settle_ff <= SETTLE_CYCLES;
            unique case (paddr[3:2])
               atpg_pkg::CSR_FRAME_WIDTH:  frame_width_ff  <= pwdata[DIM_W-1:0];
               atpg_pkg::CSR_FRAME_HEIGHT: frame_height_ff <= pwdata[DIM_W-1:0];
               atpg_pkg::CSR_ALPHA_GAIN:   alpha_gain_ff   <= pwdata[GAIN_W-1:0];
               default: ;
            endcase
         end else if (settle_ff != 2'd0) begin
            settle_ff <= settle_ff - 2'd1;
         end
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         atpg_pkg::CSR_FRAME_WIDTH:  prdata = 32'(frame_width_ff);
         atpg_pkg::CSR_FRAME_HEIGHT: prdata = 32'(frame_height_ff);
         atpg_pkg::CSR_ALPHA_GAIN:   prdata = 32'(alpha_gain_ff);
         default:                    prdata = '0;
      endcase
   end

   // geometry, four register levels behind the registers
   logic [DIM_W-1:0]  w_clamp, h_clamp;
   logic [DIM_W-1:0]  w_g1_ff, h_g1_ff;
   logic [DIM_W-1:0]  m_g2_ff, cx_g2_ff, cy_g2_ff, w8_g2_ff, h8_g2_ff;
   logic [10:0]       w4_g2_ff, h5_g2_ff;
   logic [29:0]       h5_prod, m3_prod;
   logic [11:0]       m3_g3_ff;
   logic [DIM_W-1:0]  lx_g3_ff, rx_g3_ff, ty_g3_ff, by_g3_ff;
   logic [8:0]        bar_comb, bar_g4_ff;
   logic [DIM_W-1:0]  wmb_g4_ff, hmb_g4_ff;
   logic [23:0]       r3sq_prod, r3sq_g4_ff;
   logic [21:0]       r6sq_prod, r6sq_g4_ff;
   logic [10:0]       r6_comb;

   always_comb begin
      if (frame_width_ff < atpg_pkg::MIN_DIM) begin
         w_clamp = atpg_pkg::MIN_DIM;
      end else if (int'(frame_width_ff) > MAX_DIM) begin
         w_clamp = DIM_W'(MAX_DIM);
      end else begin
         w_clamp = frame_width_ff;
      end
      if (frame_height_ff < atpg_pkg::MIN_DIM) begin
         h_clamp = atpg_pkg::MIN_DIM;
      end else if (int'(frame_height_ff) > MAX_DIM) begin
         h_clamp = DIM_W'(MAX_DIM);
      end else begin
         h_clamp = frame_height_ff;
      end
   end

   // x/3 = x*43691 >> 17 and x/5 = x*52429 >> 18, exact for 13-bit x
   assign h5_prod   = 30'(h_g1_ff) * 30'd52429;
   assign m3_prod   = 30'(m_g2_ff) * 30'd43691;
   assign bar_comb  = (m3_g3_ff[11:3] > 9'd24) ? m3_g3_ff[11:3] : 9'd24;
   assign r6_comb   = m3_g3_ff[11:1];
   assign r3sq_prod = 24'(m3_g3_ff) * 24'(m3_g3_ff);
   assign r6sq_prod = 22'(r6_comb) * 22'(r6_comb);

   always_ff @(posedge clock) begin
      w_g1_ff   <= w_clamp;
      h_g1_ff   <= h_clamp;
      m_g2_ff   <= (w_g1_ff < h_g1_ff) ? w_g1_ff : h_g1_ff;
      cx_g2_ff  <= w_g1_ff >> 1;
      cy_g2_ff  <= h_g1_ff >> 1;
      w8_g2_ff  <= w_g1_ff >> 3;
      h8_g2_ff  <= h_g1_ff >> 3;
      w4_g2_ff  <= w_g1_ff[12:2];
      h5_g2_ff  <= h5_prod[28:18];
      m3_g3_ff  <= m3_prod[28:17];
      lx_g3_ff  <= cx_g2_ff - w8_g2_ff;
      rx_g3_ff  <= cx_g2_ff + w8_g2_ff;
      ty_g3_ff  <= cy_g2_ff - h8_g2_ff;
      by_g3_ff  <= cy_g2_ff + h8_g2_ff;
      bar_g4_ff <= bar_comb;
      wmb_g4_ff <= w_g1_ff - DIM_W'(bar_comb);
      hmb_g4_ff <= h_g1_ff - DIM_W'(bar_comb);
      r3sq_g4_ff <= r3sq_prod;
      r6sq_g4_ff <= r6sq_prod;
   end

   // pixel pipeline
   logic [DIV_DONE:0]   vld_ff;
   logic [COORD_W-1:0]  x0_ff, y0_ff, x1_ff, y1_ff, x2_ff, y2_ff;
   logic [PHASE_W-1:0]  p0_ff, p_in, pc_in;
   logic [PHASE_W:0]    pc_sum;
   logic                border1_ff, border2_ff, border3_ff, border4_ff;
   logic                rect1_ff, rect2_ff, rect3_ff, rect4_ff;
   logic                circ3_ff, circ4_ff;
   logic                x_in_frame, y_in_frame;
   logic signed [13:0]  dxc1_ff, dyc1_ff, dxm3_ff, dym3_ff;
   logic signed [27:0]  sqxc, sqyc, sqxm, sqym;
   logic [26:0]         sqx2_ff, sqy2_ff, sqmx4_ff, sqmy4_ff;
   logic [18:0]         nx1_ff;
   logic [17:0]         ny1_ff;
   atpg_pkg::trig_type  cos1_ff, sin1_ff;
   logic [26:0]         prodx, prody, prodx2_ff, prody2_ff;
   logic                cneg2_ff, sneg2_ff;
   logic signed [13:0]  offx, offy;
   region_type          region_ff [REG_DLY];
   logic [QUO_W-1:0]    qx, qy;

   always_comb begin
      p_in   = (req_data.frame_phase >= PHASE_W'(atpg_pkg::PHASE_COUNT)) ?
               req_data.frame_phase - PHASE_W'(atpg_pkg::PHASE_COUNT) :
               req_data.frame_phase;
      pc_sum = {1'b0, p0_ff} + (PHASE_W + 1)'(atpg_pkg::QUARTER);
      pc_in  = (pc_sum >= (PHASE_W + 1)'(atpg_pkg::PHASE_COUNT)) ?
               PHASE_W'(pc_sum - (PHASE_W + 1)'(atpg_pkg::PHASE_COUNT)) :
               pc_sum[PHASE_W-1:0];
   end

   assign x_in_frame = ({1'b0, x0_ff} < w_g1_ff);
   assign y_in_frame = ({1'b0, y0_ff} < h_g1_ff);
   assign sqxc  = 28'(dxc1_ff) * 28'(dxc1_ff);
   assign sqyc  = 28'(dyc1_ff) * 28'(dyc1_ff);
   assign sqxm  = 28'(dxm3_ff) * 28'(dxm3_ff);
   assign sqym  = 28'(dym3_ff) * 28'(dym3_ff);
   assign prodx = 27'(cos1_ff.mag) * 27'(w4_g2_ff);
   assign prody = 27'(sin1_ff.mag) * 27'(h5_g2_ff);
   assign offx  = cneg2_ff ? -$signed({3'b000, prodx2_ff[25:15]}) :
                             $signed({3'b000, prodx2_ff[25:15]});
   assign offy  = sneg2_ff ? -$signed({3'b000, prody2_ff[25:15]}) :
                             $signed({3'b000, prody2_ff[25:15]});

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[DIV_DONE-1:0], accept};
      end
   end

   always_ff @(posedge clock) begin
      // S0
      x0_ff <= req_data.pixel_x;
      y0_ff <= req_data.pixel_y;
      p0_ff <= p_in;
      // S1
      x1_ff      <= x0_ff;
      y1_ff      <= y0_ff;
      border1_ff <= x_in_frame && y_in_frame &&
                    ({1'b0, y0_ff} < {4'b0, bar_g4_ff} || {1'b0, y0_ff} >= hmb_g4_ff ||
                     {1'b0, x0_ff} < {4'b0, bar_g4_ff} || {1'b0, x0_ff} >= wmb_g4_ff);
      rect1_ff   <= {1'b0, x0_ff} >= lx_g3_ff && {1'b0, x0_ff} < rx_g3_ff &&
                    {1'b0, y0_ff} >= ty_g3_ff && {1'b0, y0_ff} < by_g3_ff;
      dxc1_ff    <= $signed({2'b00, x0_ff}) - $signed({1'b0, cx_g2_ff});
      dyc1_ff    <= $signed({2'b00, y0_ff}) - $signed({1'b0, cy_g2_ff});
      nx1_ff     <= ({7'b0, x0_ff} << 7) - ({7'b0, x0_ff} << 3);
      ny1_ff     <= ({6'b0, y0_ff} << 6) - ({6'b0, y0_ff} << 2);
      cos1_ff    <= atpg_pkg::rom_sine(pc_in);
      sin1_ff    <= atpg_pkg::rom_sine(p0_ff);
      // S2
      x2_ff      <= x1_ff;
      y2_ff      <= y1_ff;
      border2_ff <= border1_ff;
      rect2_ff   <= rect1_ff;
      sqx2_ff    <= sqxc[26:0];
      sqy2_ff    <= sqyc[26:0];
      prodx2_ff  <= prodx;
      prody2_ff  <= prody;
      cneg2_ff   <= cos1_ff.neg;
      sneg2_ff   <= sin1_ff.neg;
      // S3
      border3_ff <= border2_ff;
      rect3_ff   <= rect2_ff;
      circ3_ff   <= ({1'b0, sqx2_ff} + {1'b0, sqy2_ff}) <= {4'b0, r3sq_g4_ff};
      dxm3_ff    <= $signed({2'b00, x2_ff}) - $signed({1'b0, cx_g2_ff}) - offx;
      dym3_ff    <= $signed({2'b00, y2_ff}) - $signed({1'b0, cy_g2_ff}) - offy;
      // S4
      border4_ff <= border3_ff;
      rect4_ff   <= rect3_ff;
      circ4_ff   <= circ3_ff;
      sqmx4_ff   <= sqxm[26:0];
      sqmy4_ff   <= sqym[26:0];
      // S5 onward: wait for the quotients
      region_ff[0] <= '{border: border4_ff, circle: circ4_ff, rect: rect4_ff,
                        moving: ({1'b0, sqmx4_ff} + {1'b0, sqmy4_ff}) <=
                                {6'b0, r6sq_g4_ff}};
      for (int k = 1; k < REG_DLY; k++) begin
         region_ff[k] <= region_ff[k-1];
      end
   end

   atpg_div #(.NUM_W(19), .DEN_W(DIM_W), .QUO_W(QUO_W)) u_div_x (
      .clock (clock),
      .num   (nx1_ff),
      .den   (w_g1_ff),
      .quo   (qx)
   );

   atpg_div #(.NUM_W(18), .DEN_W(DIM_W), .QUO_W(QUO_W)) u_div_y (
      .clock (clock),
      .num   (ny1_ff),
      .den   (h_g1_ff),
      .quo   (qy)
   );

   // color select and alpha scaling
   atpg_pkg::rsp_type pix_in, rsp_data_ff;
   logic              rsp_valid_ff;
   logic [18:0]       alpha_prod;
   region_type        reg_last;

   assign reg_last = region_ff[REG_DLY-1];

   always_comb begin
      priority if (reg_last.border) begin
         pix_in = '{blue: 8'd30, green: 8'd180, red: 8'd255, alpha: 8'd255};
      end else if (reg_last.circle) begin
         pix_in = '{blue: 8'd220, green: 8'd180 + qy[7:0], red: 8'd40 + qx[7:0],
                    alpha: 8'd128};
      end else if (reg_last.rect) begin
         pix_in = '{blue: 8'd60, green: 8'd200, red: 8'd80, alpha: 8'd255};
      end else if (reg_last.moving) begin
         pix_in = '{blue: 8'd255, green: 8'd80, red: 8'd80, alpha: 8'd200};
      end else begin
         pix_in = '{blue: 8'd0, green: 8'd0, red: 8'd0, alpha: 8'd0};
      end
      alpha_prod = 19'(pix_in.alpha) * 19'(alpha_gain_ff);
      if (alpha_gain_ff < atpg_pkg::NO_SCALE_GAIN) begin
         pix_in.alpha = alpha_prod[17:10];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= vld_ff[DIV_DONE];
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= pix_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##(DIV_DONE + 2) rsp_valid)
      else $error("taken beat did not produce a result on time");

   a_settle: assert property (@(posedge clock) disable iff (reset)
      csr_write |=> busy)
      else $error("register write did not hold off new beats");

   a_alpha_unscaled: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && alpha_gain_ff >= atpg_pkg::NO_SCALE_GAIN |->
      (rsp_data.alpha == 8'd0 || rsp_data.alpha == 8'd128 ||
       rsp_data.alpha == 8'd200 || rsp_data.alpha == 8'd255))
      else $error("unscaled alpha not a region alpha");

   a_border_color: assert property (@(posedge clock) disable iff (reset)
      vld_ff[DIV_DONE] && reg_last.border |=> rsp_data.red == 8'd255)
      else $error("border pixel lost its color");

endmodule

@@ design/atpg_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, no stall.
// Needs num < den * 2**QUO_W. Uses no package.
module atpg_div #(
   parameter int NUM_W = 19,
   parameter int DEN_W = 13,
   parameter int QUO_W = 13
) (
   input  logic             clock,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic [QUO_W-1:0] quo
);

   logic [DEN_W-1:0] rem_ff  [QUO_W];
   logic [QUO_W-1:0] low_ff  [QUO_W];
   logic [QUO_W-1:0] quo_ff  [QUO_W];
   logic [DEN_W-1:0] rem_in  [QUO_W];
   logic [QUO_W-1:0] low_in  [QUO_W];
   logic [QUO_W-1:0] quo_in  [QUO_W];
   logic [DEN_W-1:0] rem_src [QUO_W];
   logic [QUO_W-1:0] low_src [QUO_W];
   logic [QUO_W-1:0] quo_src [QUO_W];

   always_comb begin
      logic [DEN_W:0] trial;
      rem_src[0] = DEN_W'(num >> QUO_W);
      low_src[0] = num[QUO_W-1:0];
      quo_src[0] = '0;
      for (int k = 1; k < QUO_W; k++) begin
         rem_src[k] = rem_ff[k-1];
         low_src[k] = low_ff[k-1];
         quo_src[k] = quo_ff[k-1];
      end
      for (int k = 0; k < QUO_W; k++) begin
         trial = {rem_src[k], low_src[k][QUO_W-1]};
         if (trial >= {1'b0, den}) begin
            rem_in[k] = DEN_W'(trial - {1'b0, den});
            quo_in[k] = {quo_src[k][QUO_W-2:0], 1'b1};
         end else begin
            rem_in[k] = trial[DEN_W-1:0];
            quo_in[k] = {quo_src[k][QUO_W-2:0], 1'b0};
         end
         low_in[k] = {low_src[k][QUO_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < QUO_W; k++) begin
         rem_ff[k] <= rem_in[k];
         low_ff[k] <= low_in[k];
         quo_ff[k] <= quo_in[k];
      end
   end

   assign quo = quo_ff[QUO_W-1];

endmodule

@@ test/tb.sv @@
// Self-checking testbench for alpha_test_pattern_pixel_generator_unit: pixel beats go in
// through start/busy and registers through the APB port; each pixel is checked on a predictor.
// Depends on atpg_pkg and the generator RTL.
`timescale 1ns / 1ps

module tb;

   localparam int MAX_DIM     = 4096;
   localparam int CYCLE_LIMIT = 200000;

   logic              clock = 1'b0;
   logic              reset;
   logic              start;
   logic              busy;
   atpg_pkg::req_type req_data;
   logic              rsp_valid;
   atpg_pkg::rsp_type rsp_data;
   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [3:0]        paddr;
   logic [31:0]       pwdata;
   logic [31:0]       prdata;
   logic              pready;

   // predictor copy of the registers
   logic [atpg_pkg::DIM_W-1:0]  width_reg;
   logic [atpg_pkg::DIM_W-1:0]  height_reg;
   logic [atpg_pkg::GAIN_W-1:0] gain_reg;

   atpg_pkg::rsp_type expected_pixels[$];
   int      mismatches  = 0;
   int      cycle_count = 0;

   // Q1.15 quarter-wave sine, 3 degrees a step
   int sine_q15 [0:30] = '{
      0, 1715, 3425, 5126, 6813, 8481, 10126, 11743, 13328, 14876,
      16384, 17847, 19261, 20622, 21926, 23170, 24351, 25466, 26510, 27482,
      28378, 29197, 29935, 30592, 31164, 31651, 32052, 32365, 32588, 32723,
      32768
   };

   alpha_test_pattern_pixel_generator_unit #(.MAX_DIM(MAX_DIM)) DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("alpha_test_pattern_pixel_generator_unit test failed");
         $finish;
      end
   end

   function automatic longint clamp_dim(logic [atpg_pkg::DIM_W-1:0] v);
      if (v < atpg_pkg::MIN_DIM) return longint'(atpg_pkg::MIN_DIM);
      if (v > MAX_DIM) return longint'(MAX_DIM);
      return longint'(v);
   endfunction

   function automatic longint trig_q15(int p);
      int     q;
      int     r;
      int     idx;
      longint v;
      q   = (p / atpg_pkg::QUARTER) % 4;
      r   = p % atpg_pkg::QUARTER;
      idx = (q % 2 == 1) ? atpg_pkg::QUARTER - r : r;
      v   = longint'(sine_q15[idx]);
      return (q >= 2) ? -v : v;
   endfunction

   // moving circle center; division truncates toward zero
   function automatic void mover_center(int phase, output longint mx, output longint my);
      longint w;
      longint h;
      int     p;
      w  = clamp_dim(width_reg);
      h  = clamp_dim(height_reg);
      p  = phase % atpg_pkg::PHASE_COUNT;
      mx = w / 2 + trig_q15((p + atpg_pkg::QUARTER) % atpg_pkg::PHASE_COUNT) * (w / 4) / 32768;
      my = h / 2 + trig_q15(p) * (h / 5) / 32768;
   endfunction

   function automatic bit in_disc(longint x, longint y, longint cx, longint cy, longint r);
      longint dx;
      longint dy;
      dx = x - cx;
      dy = y - cy;
      return dx * dx + dy * dy <= r * r;
   endfunction

   function automatic atpg_pkg::rsp_type pattern_pixel(atpg_pkg::req_type item);
      longint  x, y, w, h, m, cx, cy, bar, mx, my, a;
      atpg_pkg::rsp_type px;
      x   = item.pixel_x;
      y   = item.pixel_y;
      w   = clamp_dim(width_reg);
      h   = clamp_dim(height_reg);
      m   = (w < h) ? w : h;
      cx  = w / 2;
      cy  = h / 2;
      bar = (m / 24 > 24) ? m / 24 : 24;
      if ((x < w && y < bar) || (x < w && y >= h - bar && y < h) ||
          (x < bar && y < h) || (x >= w - bar && x < w && y < h)) begin
         px.blue  = 8'd30;
         px.green = 8'd180;
         px.red   = 8'd255;
         a        = 255;
      end else if (in_disc(x, y, cx, cy, m / 3)) begin
         px.blue  = 8'd220;
         px.green = 8'(180 + y * 60 / h);
         px.red   = 8'(40 + x * 120 / w);
         a        = 128;
      end else if (x >= cx - w / 8 && x < cx + w / 8 && y >= cy - h / 8 && y < cy + h / 8) begin
         px.blue  = 8'd60;
         px.green = 8'd200;
         px.red   = 8'd80;
         a        = 255;
      end else begin
         mover_center(item.frame_phase, mx, my);
         if (in_disc(x, y, mx, my, m / 6)) begin
            px.blue  = 8'd255;
            px.green = 8'd80;
            px.red   = 8'd80;
            a        = 200;
         end else begin
            px.blue  = 8'd0;
            px.green = 8'd0;
            px.red   = 8'd0;
            a        = 0;
         end
      end
      if (gain_reg < atpg_pkg::NO_SCALE_GAIN) a = (a * gain_reg) >> 10;
      px.alpha = 8'(a);
      return px;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] want, logic [63:0] got);
      mismatches++;
      if (mismatches <= 10) $display("%s mismatch: expected %h, got %h", what, want, got);
   endtask

   always @(posedge clock) begin : check_pixels
      atpg_pkg::rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_pixels.size() == 0) begin
            report_mismatch("unexpected pixel", 64'd0, rsp_data);
         end else begin
            want = expected_pixels.pop_front();
            if (rsp_data.blue !== want.blue || rsp_data.green !== want.green ||
                rsp_data.red !== want.red || rsp_data.alpha !== want.alpha) begin
               report_mismatch("pixel", want, rsp_data);
            end
         end
      end
   end

   task automatic send_pixel(atpg_pkg::req_type item);
      @(negedge clock);
      start    = 1'b1;
      req_data = item;
      do @(posedge clock); while (busy);
      expected_pixels.push_back(pattern_pixel(item));
   endtask

   task automatic pause_req(int n);
      if (n > 0) begin
         @(negedge clock);
         start = 1'b0;
         repeat (n - 1) @(negedge clock);
      end
   endtask

   function automatic int random_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic drain();
      @(negedge clock);
      start = 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] index, logic [31:0] value);
      logic [31:0] readback;
      logic [31:0] stored;
      drain();
      @(negedge clock);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = {index, 2'b00};
      pwdata  = value;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      case (index)
         atpg_pkg::CSR_FRAME_WIDTH: begin
            width_reg = value[atpg_pkg::DIM_W-1:0];
            stored    = 32'(width_reg);
         end
         atpg_pkg::CSR_FRAME_HEIGHT: begin
            height_reg = value[atpg_pkg::DIM_W-1:0];
            stored     = 32'(height_reg);
         end
         default: begin
            gain_reg = value[atpg_pkg::GAIN_W-1:0];
            stored   = 32'(gain_reg);
         end
      endcase
      @(negedge clock);
      pwrite  = 1'b0;
      penable = 1'b0;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      readback = prdata;
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      if (readback !== stored) report_mismatch("register readback", stored, readback);
   endtask

   task automatic set_geometry(logic [31:0] w, logic [31:0] h, logic [31:0] g);
      write_csr(atpg_pkg::CSR_FRAME_WIDTH, w);
      write_csr(atpg_pkg::CSR_FRAME_HEIGHT, h);
      write_csr(atpg_pkg::CSR_ALPHA_GAIN, g);
   endtask

   // reset geometry: bars, circle edge, pixels past the frame
   task automatic test_default_regions();
      int      pts [9][2] = '{'{0, 0}, '{1919, 1079}, '{960, 540}, '{600, 540}, '{599, 540},
                              '{4095, 4095}, '{4095, 0}, '{44, 540}, '{45, 540}};
      atpg_pkg::req_type item;
      for (int i = 0; i < 9; i++) begin
         item.pixel_x     = 12'(pts[i][0]);
         item.pixel_y     = 12'(pts[i][1]);
         item.frame_phase = '0;
         send_pixel(item);
         pause_req(random_gap());
      end
   endtask

   // pixel at the moving circle center, including phases past the wrap
   task automatic test_moving_phases();
      int      phases [9] = '{0, 15, 45, 60, 75, 105, 119, 120, 127};
      longint  mx;
      longint  my;
      atpg_pkg::req_type item;
      for (int i = 0; i < 9; i++) begin
         mover_center(phases[i], mx, my);
         item.pixel_x     = 12'(mx);
         item.pixel_y     = 12'(my);
         item.frame_phase = 7'(phases[i]);
         send_pixel(item);
         pause_req(random_gap());
      end
   endtask

   // size registers beyond both clamps, gain at zero and just below no-scale
   task automatic test_extreme_sizes();
      atpg_pkg::req_type item;
      set_geometry(32'd8191, 32'd0, 32'd0);
      item = '{pixel_x: 12'd2348, pixel_y: 12'd32, frame_phase: 7'd0};
      send_pixel(item);
      item = '{pixel_x: 12'd4095, pixel_y: 12'd63, frame_phase: 7'd64};
      send_pixel(item);
      item = '{pixel_x: 12'd2048, pixel_y: 12'd32, frame_phase: 7'd127};
      send_pixel(item);
      set_geometry(32'd64, 32'd64, 32'd1022);
      item = '{pixel_x: 12'd32, pixel_y: 12'd32, frame_phase: 7'd0};
      send_pixel(item);
      item = '{pixel_x: 12'd0, pixel_y: 12'd63, frame_phase: 7'd0};
      send_pixel(item);
   endtask

   task automatic random_pixels(int count, bit back_to_back);
      longint  w, h, m, mx, my, r, off, px, py;
      int      pick;
      atpg_pkg::req_type item;
      w = clamp_dim(width_reg);
      h = clamp_dim(height_reg);
      m = (w < h) ? w : h;
      for (int i = 0; i < count; i++) begin
         item.frame_phase = 7'($urandom_range(0, 127));
         pick             = $urandom_range(0, 99);
         if (pick < 15) begin
            px = $urandom_range(0, 4095);
            py = $urandom_range(0, 4095);
         end else if (pick < 45) begin
            mover_center(item.frame_phase, mx, my);
            r   = m / 6 + 4;
            off = $urandom_range(0, 32'(2 * r));
            px  = mx + off - r;
            off = $urandom_range(0, 32'(2 * r));
            py  = my + off - r;
         end else begin
            px = $urandom_range(0, 32'(w - 1));
            py = $urandom_range(0, 32'(h - 1));
         end
         item.pixel_x = 12'((px < 0) ? 0 : (px > 4095) ? 4095 : px);
         item.pixel_y = 12'((py < 0) ? 0 : (py > 4095) ? 4095 : py);
         send_pixel(item);
         if (!back_to_back) pause_req(random_gap());
      end
   endtask

   task automatic test_random_settings();
      logic [31:0] widths  [6];
      logic [31:0] heights [6];
      logic [31:0] gains   [6];
      widths  = '{32'd64, 32'd4096, 32'd0, 32'd1920, 32'd0, 32'd0};
      heights = '{32'd64, 32'd4096, 32'd8191, 32'd1080, 32'd0, 32'd0};
      gains   = '{32'd0, 32'd1022, 32'd2047, 32'd1023, 32'd0, 32'd0};
      for (int i = 4; i < 6; i++) begin
         widths[i]  = $urandom_range(0, 8191);
         heights[i] = $urandom_range(0, 8191);
         gains[i]   = $urandom_range(0, 2047);
      end
      for (int i = 0; i < 6; i++) begin
         set_geometry(widths[i], heights[i], gains[i]);
         random_pixels(222, i % 2 == 1);
      end
   endtask

   initial begin
      reset      = 1'b1;
      start      = 1'b0;
      req_data   = '0;
      psel       = 1'b0;
      penable    = 1'b0;
      pwrite     = 1'b0;
      paddr      = '0;
      pwdata     = '0;
      width_reg  = atpg_pkg::WIDTH_RESET;
      height_reg = atpg_pkg::HEIGHT_RESET;
      gain_reg   = atpg_pkg::GAIN_RESET;
      repeat (3) @(negedge clock);
      reset = 1'b0;

      test_default_regions();
      test_moving_phases();
      test_extreme_sizes();
      test_random_settings();

      drain();
      repeat (30) @(posedge clock);
      if (mismatches == 0) begin
         $display("alpha_test_pattern_pixel_generator_unit test passed");
      end else begin
         $display("alpha_test_pattern_pixel_generator_unit test failed");
      end
      $finish;
   end

endmodule
